[rtl/core/iscc_pkg.sv]
`timescale 1ns / 1ps

package iscc_pkg;

  // field widths fixed by the word format
  localparam int VALUE_W     = 32;
  localparam int COMP_W      = 7;
  localparam int COMP_MAX    = 127;
  localparam int OUT_TDATA_W = 40;

  // default store depth
  localparam int SORT_DEPTH_DEF = 16;

  // controller states
  typedef enum logic [1:0] {
    S_IDLE,
    S_COUNT,
    S_EMIT
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic insert;
    logic count;
    logic pop;
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic held_one;
  } status_t;

endpackage

[rtl/core/insertion_sort_comparison_counter_core.sv]
`timescale 1ns / 1ps
// insertion sort with comparison counter
// input: each accepted word is inserted, then the count is updated, before the next word is taken
// output: first sorted word valid after the last word's count update, then one word
//   per cycle while out_tready is high; no input is taken while results drain
// reset: synchronous active-low rst_n clears fill count, comparison total, overflow
//   flag and controller state; the sort cells are not cleared

module insertion_sort_comparison_counter_core #(
  parameter int SORT_DEPTH = iscc_pkg::SORT_DEPTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [iscc_pkg::VALUE_W-1:0]     in_tdata,   // [31:0] value
  input  logic                             in_tlast,   // last_in
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [iscc_pkg::OUT_TDATA_W-1:0] out_tdata,  // [31:0] sorted_value,
                                                       // [38:32] comparisons,
                                                       // [39] overflowed
  output logic                             out_tlast   // last_out
);

  iscc_pkg::cmd_t    cmd;
  iscc_pkg::status_t status;

  logic signed [iscc_pkg::VALUE_W-1:0] sorted_value;
  logic        [iscc_pkg::COMP_W-1:0]  comparisons;
  logic                                overflowed;

  iscc_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  iscc_dpath #(
    .SORT_DEPTH (SORT_DEPTH)
  ) u_dpath (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .value        ($signed(in_tdata)),
    .status       (status),
    .sorted_value (sorted_value),
    .comparisons  (comparisons),
    .overflowed   (overflowed)
  );

  // output word packing
  assign out_tdata = {overflowed, comparisons, sorted_value};
  assign out_tlast = status.held_one;

`ifndef SYNTHESIS
  // results and input never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input ready while results pending");

  // an accepted word is followed by its count cycle
  a_count_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (!in_tready && !out_tvalid))
    else $error("no count cycle after insert");

  // draining continues until the last word
  a_drain_cont: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=> out_tvalid)
    else $error("drain stopped early");

  // drain ends after the last word
  a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> (!out_tvalid && in_tready))
    else $error("drain did not end on last word");
`endif

endmodule

[rtl/core/iscc_ctrl.sv]
`timescale 1ns / 1ps

module iscc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  iscc_pkg::status_t status,
  output iscc_pkg::cmd_t    cmd
);

  iscc_pkg::state_t state_r, state_nxt;
  logic             last_r, last_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= iscc_pkg::S_IDLE;
      last_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      last_r  <= last_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt  = state_r;
    last_nxt   = last_r;
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    cmd        = '0;
    case (state_r)
      iscc_pkg::S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.insert = 1'b1;
          last_nxt   = in_tlast;
          state_nxt  = iscc_pkg::S_COUNT;
        end
      end
      iscc_pkg::S_COUNT: begin
        cmd.count = 1'b1;
        state_nxt = last_r ? iscc_pkg::S_EMIT : iscc_pkg::S_IDLE;
      end
      iscc_pkg::S_EMIT: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          cmd.pop = 1'b1;
          if (status.held_one) begin
            state_nxt = iscc_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = iscc_pkg::S_IDLE;
      end
    endcase
  end

endmodule

[rtl/core/iscc_dpath.sv]
`timescale 1ns / 1ps

module iscc_dpath #(
  parameter int SORT_DEPTH = iscc_pkg::SORT_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  iscc_pkg::cmd_t                      cmd,
  input  logic signed [iscc_pkg::VALUE_W-1:0] value,
  output iscc_pkg::status_t                   status,
  output logic signed [iscc_pkg::VALUE_W-1:0] sorted_value,
  output logic        [iscc_pkg::COMP_W-1:0]  comparisons,
  output logic                                overflowed
);

  localparam int IW    = $clog2(SORT_DEPTH);
  localparam int HW    = $clog2(SORT_DEPTH + 1);
  localparam int SUM_W = iscc_pkg::COMP_W + 1;

  logic signed [iscc_pkg::VALUE_W-1:0] store_r   [SORT_DEPTH];
  logic signed [iscc_pkg::VALUE_W-1:0] store_nxt [SORT_DEPTH];
  logic [HW-1:0]                  held_r;
  logic [iscc_pkg::COMP_W-1:0]    total_r;
  logic                           ovf_r;
  logic                           ins_r;
  logic [IW-1:0]                  pos_r, pos_nxt;
  logic [HW-1:0]                  held_before_r;
  logic [SORT_DEPTH-1:0]          at_or_after;
  logic [SORT_DEPTH-1:0]          edge_hit;
  logic                           full;
  logic [HW-1:0]                  add;
  logic [SUM_W-1:0]               sum;

  assign full = (held_r == HW'(SORT_DEPTH));

  // per-cell compare: set from the insert position onward (empty cells count as set)
  always_comb begin
    for (int k = 0; k < SORT_DEPTH; k++) begin
      at_or_after[k] = (HW'(k) >= held_r) || (store_r[k] > value);
    end
    for (int k = 0; k < SORT_DEPTH; k++) begin
      if (k == 0) begin
        edge_hit[k] = at_or_after[k];
      end else begin
        edge_hit[k] = at_or_after[k] && !at_or_after[k-1];
      end
    end
  end

  // one-hot insert position to binary
  always_comb begin
    pos_nxt = '0;
    for (int k = 0; k < SORT_DEPTH; k++) begin
      if (edge_hit[k]) begin
        pos_nxt = pos_nxt | IW'(k);
      end
    end
  end

  // shift-insert or shift-out of the cell row
  always_comb begin
    for (int k = 0; k < SORT_DEPTH; k++) begin
      store_nxt[k] = store_r[k];
      if (cmd.insert && !full) begin
        if (at_or_after[k]) begin
          if (k > 0 && at_or_after[(k > 0) ? k-1 : 0]) begin
            store_nxt[k] = store_r[(k > 0) ? k-1 : 0];
          end else begin
            store_nxt[k] = value;
          end
        end
      end else if (cmd.pop && k < SORT_DEPTH - 1) begin
        store_nxt[k] = store_r[(k < SORT_DEPTH - 1) ? k+1 : k];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < SORT_DEPTH; k++) begin
      store_r[k] <= store_nxt[k];
    end
  end

  // comparison count for the last insertion
  assign add = (pos_r == '0) ? held_before_r
                             : HW'(held_before_r - HW'(pos_r) + HW'(1));
  assign sum = SUM_W'(total_r) + SUM_W'(add);

  // counters and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r  <= '0;
      total_r <= '0;
      ovf_r   <= 1'b0;
      ins_r   <= 1'b0;
    end else begin
      if (cmd.insert) begin
        ins_r <= !full;
        if (full) begin
          ovf_r <= 1'b1;
        end else begin
          held_r <= held_r + HW'(1);
        end
      end
      if (cmd.count && ins_r) begin
        if (sum > SUM_W'(iscc_pkg::COMP_MAX)) begin
          total_r <= iscc_pkg::COMP_W'(iscc_pkg::COMP_MAX);
        end else begin
          total_r <= sum[iscc_pkg::COMP_W-1:0];
        end
      end
      if (cmd.pop) begin
        held_r <= held_r - HW'(1);
        if (held_r == HW'(1)) begin
          total_r <= '0;
          ovf_r   <= 1'b0;
        end
      end
    end
  end

  // insert position and prior fill, registered for the count update that follows
  always_ff @(posedge clk) begin
    if (cmd.insert) begin
      pos_r         <= pos_nxt;
      held_before_r <= held_r;
    end
  end

  assign status.held_one = (held_r == HW'(1));
  assign sorted_value    = store_r[0];
  assign comparisons     = total_r;
  assign overflowed      = ovf_r;

endmodule
